// File: design/sha1sh_pkg.sv
// Shared types and constants for the SHA-1 stream hasher
package sha1sh_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned BlockBytes = 64;
   localparam int unsigned RoundCount = 80;

   localparam logic [31:0] Iv0 = 32'h67452301;
   localparam logic [31:0] Iv1 = 32'hefcdab89;
   localparam logic [31:0] Iv2 = 32'h98badcfe;
   localparam logic [31:0] Iv3 = 32'h10325476;
   localparam logic [31:0] Iv4 = 32'hc3d2e1f0;
   localparam logic [7:0]  PadByte = 8'h80;

   localparam logic [0:0] CmdAbsorb = 1'b0;
   localparam logic [0:0] CmdFinish = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic store_byte;   // write req byte at fill position
      logic pad_write;    // write pad/zero/length byte at pad position
      logic round_start;  // load working vars from chain
      logic round_step;   // one round
      logic fold;         // add working vars into chain
      logic chain_reset;  // back to initial vector
      logic load_out;     // capture digest
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic       block_full;  // fill count reached 64
      logic       last_round;  // round counter at 79
      logic [6:0] pad_pos;     // current pad write position (0..64)
      logic       len_done;    // pad position reached 64
   } stat_type;

   function automatic logic [31:0] k_const(input logic [6:0] r);
      if (r < 7'd20)      return 32'h5a827999;
      else if (r < 7'd40) return 32'h6ed9eba1;
      else if (r < 7'd60) return 32'h8f1bbcdc;
      else                return 32'hca62c1d6;
   endfunction

   function automatic logic [31:0] f_func(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
      if (r < 7'd20)      return (b & c) | (~b & d);
      else if (r < 7'd40) return b ^ c ^ d;
      else if (r < 7'd60) return (b & c) | (b & d) | (c & d);
      else                return b ^ c ^ d;
   endfunction

endpackage

// File: design/sha1sh_if.sv
// Valid/ready stream interfaces for request and response words
interface sha1sh_req_if;
   logic       valid;
   logic       ready;
   logic [0:0] command;
   logic [7:0] message_byte;
   modport source (output valid, command, message_byte, input ready);
   modport sink (input valid, command, message_byte, output ready);
endinterface

interface sha1sh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word_0;
   logic [31:0] digest_word_1;
   logic [31:0] digest_word_2;
   logic [31:0] digest_word_3;
   logic [31:0] digest_word_4;
   modport source (output valid, digest_word_0, digest_word_1, digest_word_2,
                   digest_word_3, digest_word_4, input ready);
   modport sink (input valid, digest_word_0, digest_word_1, digest_word_2,
                 digest_word_3, digest_word_4, output ready);
endinterface

// File: design/sha1sh_datapath.sv
// Block buffer, message schedule, round unit and chaining words
module sha1sh_datapath
   import sha1sh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ctrl_type    ctrl,
   input  logic [7:0]  in_byte,
   input  logic        len_phase,
   output stat_type    stat,
   output logic [31:0] dig_0,
   output logic [31:0] dig_1,
   output logic [31:0] dig_2,
   output logic [31:0] dig_3,
   output logic [31:0] dig_4
);
   // block held as 16 words; shifts as the schedule window during rounds
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [6:0]  fill_ff, fill_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [63:0] bits_ff, bits_in;
   logic [31:0] o_ff [5];
   logic [31:0] sched_new, tmp;
   logic [5:0]  wpos;
   logic [7:0]  wbyte;
   logic        wen;
   logic [2:0]  lidx;

   assign sched_new = {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]};
   assign tmp = {a_ff[26:0], a_ff[31:27]} + f_func(rnd_ff, b_ff, c_ff, d_ff) + e_ff
                + k_const(rnd_ff) + w_ff[0];

   // length bytes: position 56..63 selects big-endian byte of bit count
   assign lidx = fill_ff[2:0];

   always_comb begin
      wen = ctrl.store_byte | ctrl.pad_write;
      wpos = fill_ff[5:0];
      if (ctrl.store_byte) wbyte = in_byte;
      else if (len_phase) wbyte = bits_ff[8*(7-lidx) +: 8];
      else if (fill_ff == stat.pad_pos && 1'b0) wbyte = 8'h00;
      else wbyte = 8'h00;
   end

   // pad byte marker: first pad write after finish carries 0x80
   logic pad_first_ff, pad_first_in;

   always_comb begin
      for (int i = 0; i < 16; i++) w_in[i] = w_ff[i];
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      for (int i = 0; i < 5; i++) h_in[i] = h_ff[i];
      fill_in = fill_ff;
      rnd_in = rnd_ff;
      bits_in = bits_ff;
      pad_first_in = pad_first_ff;
      if (wen) begin
         w_in[wpos[5:2]][8*(3-wpos[1:0]) +: 8] =
            (ctrl.pad_write && pad_first_ff) ? PadByte : wbyte;
         fill_in = fill_ff + 7'd1;
         if (ctrl.pad_write) pad_first_in = 1'b0;
      end
      if (ctrl.store_byte) bits_in = bits_ff + 64'd8;
      if (ctrl.round_start) begin
         a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3]; e_in = h_ff[4];
         rnd_in = '0;
         fill_in = '0;
      end
      if (ctrl.round_step) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = {sched_new[30:0], sched_new[31]};
         e_in = d_ff; d_in = c_ff; c_in = {b_ff[1:0], b_ff[31:2]}; b_in = a_ff; a_in = tmp;
         rnd_in = rnd_ff + 7'd1;
      end
      if (ctrl.fold) begin
         h_in[0] = h_ff[0] + a_ff; h_in[1] = h_ff[1] + b_ff; h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff; h_in[4] = h_ff[4] + e_ff;
      end
      if (ctrl.chain_reset) begin
         h_in[0] = Iv0; h_in[1] = Iv1; h_in[2] = Iv2; h_in[3] = Iv3; h_in[4] = Iv4;
         fill_in = '0;
         bits_in = '0;
         pad_first_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) w_ff[i] <= w_in[i];
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      rnd_ff <= rnd_in;
      if (ctrl.load_out) for (int i = 0; i < 5; i++) o_ff[i] <= h_ff[i];
      if (reset) begin
         h_ff[0] <= Iv0; h_ff[1] <= Iv1; h_ff[2] <= Iv2; h_ff[3] <= Iv3; h_ff[4] <= Iv4;
         fill_ff <= '0;
         bits_ff <= '0;
         pad_first_ff <= 1'b1;
      end else begin
         for (int i = 0; i < 5; i++) h_ff[i] <= h_in[i];
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         pad_first_ff <= pad_first_in;
      end
   end

   assign stat.block_full = (fill_ff == 7'd64);
   assign stat.last_round = (rnd_ff == 7'(RoundCount - 1));
   assign stat.pad_pos = fill_ff;
   assign stat.len_done = (fill_ff == 7'd64);
   assign dig_0 = o_ff[0];
   assign dig_1 = o_ff[1];
   assign dig_2 = o_ff[2];
   assign dig_3 = o_ff[3];
   assign dig_4 = o_ff[4];
endmodule

// File: design/sha1sh_ctrl.sv
// Sequencer for absorb, padding, compression and digest hand-off
module sha1sh_ctrl
   import sha1sh_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_fire,
   input  logic      req_finish,
   input  logic      rsp_taken,
   input  stat_type  stat,
   output ctrl_type  ctrl,
   output logic      idle,
   output logic      len_phase,
   output logic      rsp_pending
);
   state_type state_ff, state_in;
   logic      fin_ff, fin_in;    // finish in progress
   logic      extra_ff, extra_in; // pad block needs a second compression
   // tracks whether the length has been written into the current finish
   logic      lenseen_ff, lenseen_in;

   always_comb begin
      state_in = state_ff;
      fin_in = fin_ff;
      extra_in = extra_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_finish) begin
               state_in = ST_PAD;
               fin_in = 1'b1;
            end else if (req_fire && stat.pad_pos == 7'd63) begin
               state_in = ST_ROUND;
            end
         end
         ST_PAD: begin
            // pad byte then zeros up to 56, or to 64 when overflowing
            if (stat.pad_pos == 7'd63 && extra_ff == 1'b0 && !len_phase) begin
               state_in = ST_ROUND;
               extra_in = 1'b1;
            end else if (stat.pad_pos == 7'd55) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN:   if (stat.pad_pos == 7'd63) state_in = ST_ROUND;
         ST_ROUND: if (stat.last_round) state_in = ST_FOLD;
         ST_FOLD: begin
            if (!fin_ff)      state_in = ST_IDLE;
            else if (extra_ff && stat.pad_pos == 7'd0 && !lenseen_ff) state_in = ST_PAD;
            else              state_in = ST_OUT;
         end
         ST_OUT: if (!rsp_pending || rsp_taken) begin
            state_in = ST_IDLE;
            fin_in = 1'b0;
            extra_in = 1'b0;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign lenseen_in = (state_ff == ST_LEN) ? 1'b1 :
                       (state_ff == ST_OUT) ? 1'b0 : lenseen_ff;

   logic pend_ff, pend_in;
   always_comb begin
      pend_in = pend_ff;
      if (rsp_taken) pend_in = 1'b0;
      if (state_ff == ST_OUT && (!pend_ff || rsp_taken)) pend_in = 1'b1;
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE:  ctrl.store_byte = req_fire && !req_finish;
         ST_PAD:   ctrl.pad_write = 1'b1;
         ST_LEN:   ctrl.pad_write = 1'b1;
         ST_ROUND: ctrl.round_step = 1'b1;
         ST_FOLD:  ctrl.fold = 1'b1;
         ST_OUT: begin
            ctrl.load_out = !pend_ff || rsp_taken;
            ctrl.chain_reset = !pend_ff || rsp_taken;
         end
         default: ctrl = '0;
      endcase
      // working vars load on entry to the rounds
      ctrl.round_start = (state_in == ST_ROUND) && (state_ff != ST_ROUND);
   end

   assign idle = (state_ff == ST_IDLE);
   assign len_phase = (state_ff == ST_LEN);
   assign rsp_pending = pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff <= 1'b0;
         extra_ff <= 1'b0;
         lenseen_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff <= fin_in;
         extra_ff <= extra_in;
         lenseen_ff <= lenseen_in;
         pend_ff <= pend_in;
      end
   end
endmodule

// File: design/sha1_stream_hasher_unit.sv
// Top level of the streaming SHA-1 hasher
//  channel | dir | words carried
//  req_    | in  | command, message_byte
//  rsp_    | out | digest_word_0..4 (one response per finish)
//
// Absorb words are accepted while the unit is idle; the 64th byte of a block starts
// the rounds and a fold on the single shared round unit, and no word is taken meanwhile.
// A finish writes pad bytes one per cycle (to byte 63), runs one or two
// compressions, then loads the digest register once any earlier digest
// on rsp_ has been taken.
// Synchronous active-high reset restores the initial vector and counts.
// The digest register holds while rsp_ is stalled; a new finish waits for it.
module sha1_stream_hasher_unit
   import sha1sh_pkg::*;
(
   input logic         clock,
   input logic         reset,
   sha1sh_req_if.sink   req,
   sha1sh_rsp_if.source rsp
);
   ctrl_type ctrl;
   stat_type stat;
   logic     idle, len_phase, rsp_pending;
   logic     req_fire, rsp_taken;

   assign req.ready = idle;
   assign req_fire = req.valid && req.ready;
   assign rsp_taken = rsp.valid && rsp.ready;
   assign rsp.valid = rsp_pending;

   sha1sh_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .req_finish(req.command == CmdFinish), .rsp_taken(rsp_taken),
      .stat(stat), .ctrl(ctrl), .idle(idle), .len_phase(len_phase),
      .rsp_pending(rsp_pending)
   );

   sha1sh_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .in_byte(req.message_byte),
      .len_phase(len_phase), .stat(stat),
      .dig_0(rsp.digest_word_0), .dig_1(rsp.digest_word_1), .dig_2(rsp.digest_word_2),
      .dig_3(rsp.digest_word_3), .dig_4(rsp.digest_word_4)
   );

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      stat.pad_pos <= 7'd64) else $error("fill count out of range");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.round_step |-> !req_fire) else $error("word accepted during rounds");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("response dropped");
endmodule

// File: tb/tb_sha1_stream_hasher_unit.sv
// Testbench for the streaming SHA-1 hasher: directed and random messages checked against a digest predictor
module tb_sha1_stream_hasher_unit;
   import sha1sh_pkg::*;

   typedef struct packed {
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      logic [31:0] w4;
   } digest_type;

   logic clock;
   logic reset;

   sha1sh_req_if req ();
   sha1sh_rsp_if rsp ();

   sha1_stream_hasher_unit dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: chain words, pending block bytes, message bit length
   logic [31:0] chain_words [5];
   logic [7:0]  block_bytes [64];
   int unsigned pending_bytes;
   logic [63:0] message_bits;

   digest_type  digest_queue [$];
   int unsigned mismatch_count;
   int unsigned digest_count;
   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // one 80-round compression of block_bytes into chain_words
   task automatic fold_block();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, fn, kc, tmp;
      for (int r = 0; r < 16; r++)
         sched[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
                     block_bytes[4*r+3]};
      for (int r = 16; r < 80; r++)
         sched[r] = rotl32(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
      a = chain_words[0]; b = chain_words[1]; c = chain_words[2];
      d = chain_words[3]; e = chain_words[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 20) begin
            fn = (b & c) | (~b & d); kc = 32'h5a827999;
         end else if (r < 40) begin
            fn = b ^ c ^ d; kc = 32'h6ed9eba1;
         end else if (r < 60) begin
            fn = (b & c) | (b & d) | (c & d); kc = 32'h8f1bbcdc;
         end else begin
            fn = b ^ c ^ d; kc = 32'hca62c1d6;
         end
         tmp = rotl32(a, 5) + fn + e + kc + sched[r];
         e = d; d = c; c = rotl32(b, 30); b = a; a = tmp;
      end
      chain_words[0] += a; chain_words[1] += b; chain_words[2] += c;
      chain_words[3] += d; chain_words[4] += e;
   endtask

   task automatic restart_message();
      chain_words[0] = Iv0; chain_words[1] = Iv1; chain_words[2] = Iv2;
      chain_words[3] = Iv3; chain_words[4] = Iv4;
      pending_bytes = 0;
      message_bits = '0;
   endtask

   // advance the predictor by one accepted word
   task automatic predict_word(input logic [0:0] cmd, input logic [7:0] data);
      int unsigned pos;
      if (cmd == CmdAbsorb) begin
         block_bytes[pending_bytes] = data;
         message_bits += 64'd8;
         pending_bytes++;
         if (pending_bytes == BlockBytes) begin
            fold_block();
            pending_bytes = 0;
         end
      end else begin
         pos = pending_bytes;
         block_bytes[pos] = PadByte;
         pos++;
         // more than 55 bytes pending: length spills into an extra block
         if (pos > 56) begin
            for (int i = pos; i < 64; i++) block_bytes[i] = 8'h00;
            fold_block();
            pos = 0;
         end
         for (int i = pos; i < 56; i++) block_bytes[i] = 8'h00;
         for (int i = 0; i < 8; i++) block_bytes[56+i] = message_bits[63-8*i -: 8];
         fold_block();
         digest_queue.push_back({chain_words[0], chain_words[1], chain_words[2],
                                 chain_words[3], chain_words[4]});
         restart_message();
      end
   endtask

   // drive one word, wait for its acceptance, idle at random beforehand;
   // valid stays up after acceptance until the next idle cycle or word
   task automatic send_word(input logic [0:0] cmd, input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.command <= cmd;
      req.message_byte <= data;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_word(cmd, data);
   endtask

   task automatic send_message(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) send_word(CmdAbsorb, 8'($urandom));
      send_word(CmdFinish, 8'($urandom));
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   // response checker: compare each accepted digest with the oldest expected one
   always @(posedge clock) begin
      digest_type got, want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = {rsp.digest_word_0, rsp.digest_word_1, rsp.digest_word_2,
                   rsp.digest_word_3, rsp.digest_word_4};
            digest_count++;
            if (digest_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected digest %h", got);
            end else begin
               want = digest_queue.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("digest mismatch: expected %h got %h", want, got);
               end
            end
         end
         rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // classic vectors: empty, "abc", and the 56-byte two-block string
   task automatic test_known_vectors();
      string s;
      send_word(CmdFinish, 8'hff);
      s = "abc";
      foreach (s[i]) send_word(CmdAbsorb, s[i]);
      send_word(CmdFinish, 8'h00);
      s = "abcdbcdecdefdefgefghfghighijhijkijkljklmklmnlmnomnopnopq";
      foreach (s[i]) send_word(CmdAbsorb, s[i]);
      send_word(CmdFinish, 8'h00);
   endtask

   // padding boundaries: 55, 56, 63, 64 bytes, plus byte extremes
   task automatic test_pad_edges();
      send_word(CmdAbsorb, 8'h00);
      send_word(CmdFinish, 8'h00);
      send_word(CmdAbsorb, 8'hff);
      send_word(CmdFinish, 8'hff);
      send_message(55);
      send_message(56);
      send_message(63);
      send_message(64);
   endtask

   // hold-off: stop sending until every outstanding digest has arrived
   task automatic test_drain_pause();
      send_message($urandom_range(70));
      wait_drained();
      send_message($urandom_range(130));
   endtask

   // random messages, lengths mostly short with the odd multi-block one
   task automatic test_random_messages(input int unsigned words);
      int unsigned sent, len;
      sent = 0;
      while (sent < words) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(70);
         send_message(len);
         sent += len + 1;
      end
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.command = CmdAbsorb;
      req.message_byte = 8'h00;
      mismatch_count = 0;
      digest_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      restart_message();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_known_vectors();
      test_pad_edges();
      test_drain_pause();
      test_random_messages(230);
      send_idle_pct = 74;
      test_random_messages(230);
      send_idle_pct = 0;
      rsp_stall_pct = 74;
      test_random_messages(230);
      send_idle_pct = 25;
      rsp_stall_pct = 25;
      test_random_messages(230);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_messages(30);

      wait_drained();
      repeat (300) @(posedge clock);
      $display("covered: known vectors, pad boundaries 55/56/63/64, multi-block messages,");
      $display("  %0d digests checked under sender and receiver idling", digest_count);
      if (mismatch_count == 0 && digest_queue.size() == 0)
         $display("tb_sha1_stream_hasher_unit: clean");
      else
         $display("tb_sha1_stream_hasher_unit: errors");
      $finish;
   end

   initial begin
      #20000000;
      $display("tb_sha1_stream_hasher_unit: errors");
      $finish;
   end

endmodule
